// File: rtl/mbrs_pkg.sv
// ----------------------------------------------------------------------------
// mbrs_pkg
// shared types, function codes and helpers of the register server
// ----------------------------------------------------------------------------
package mbrs_pkg;

  localparam logic [7:0] FnRead   = 8'h03;
  localparam logic [7:0] FnWrite1 = 8'h06;
  localparam logic [7:0] FnWriteN = 8'h10;
  localparam logic [7:0] AddrReset = 8'h01;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  // register byte addresses on the configuration port
  localparam logic [1:0] RegSlaveAddr = 2'd0;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_HDR, ST_JUDGE, ST_RDREQ, ST_RDWAIT,
    ST_WRFETCH, ST_WRLO, ST_WRMEM, ST_EMIT, ST_CRCLO, ST_CRCHI
  } state_e;

  // one byte through the reflected 0xA001 polynomial, eight narrow steps
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    end
    return r;
  endfunction

endpackage

// File: rtl/mbrs_ram.sv
// ----------------------------------------------------------------------------
// mbrs_ram
// generic single port write, single port read ram with registered read
// ----------------------------------------------------------------------------
module mbrs_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/modbus_rtu_slave_register_server_unit.sv
// ----------------------------------------------------------------------------
// modbus_rtu_slave_register_server_unit
// modbus rtu slave answering function codes 03, 06 and 10
// ----------------------------------------------------------------------------
// Received bytes enter on rx_byte_i/frame_end_i, one beat each, and are
// stored in a frame ram while a crc runs over them. A beat with frame_end_i
// set closes the frame; the block then judges it and, if it is addressed to
// slave_address with a good crc and length, reads or writes the word ram and
// emits the response on tx_byte_o/tx_last_o. A non-final byte is taken while
// idle and leaves it idle. A closed frame is judged by seven header reads and
// a decision; for function 10 each word then passes ST_WRFETCH, ST_WRLO and
// ST_WRMEM; each response byte before the crc passes ST_EMIT, ST_RDREQ and
// ST_RDWAIT (word ram read or gathered header, one crc step), each crc byte
// its own state; rx stalls meanwhile. A tx stall holds the beat and the block.
// After reset the word ram is cleared one word a cycle, all MEM_WORDS words, with
// rx stalled; configuration writes are taken throughout. slave_address sits at
// byte address 0 and resets to 1.
// ----------------------------------------------------------------------------
module modbus_rtu_slave_register_server_unit #(
  parameter int FRAME_BYTES    = 256,
  parameter int MEM_WORDS      = 4096,
  parameter int MAX_READ_WORDS = 29
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       psel_i,
  input  logic       penable_i,
  input  logic       pwrite_i,
  input  logic [1:0] paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic       pready_o,
  input  logic       rx_valid_i,
  output logic       rx_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       frame_end_i,
  output logic       tx_valid_o,
  input  logic       tx_stall_i,
  output logic [7:0] tx_byte_o,
  output logic       tx_last_o
);

  localparam int FAW = $clog2(FRAME_BYTES);
  localparam int MAW = $clog2(MEM_WORDS);
  localparam int CW  = FAW + 1;
  localparam logic [CW-1:0] FrameFull = CW'(FRAME_BYTES);
  localparam logic [CW-1:0] FrameOvf  = CW'(FRAME_BYTES + 1);

  mbrs_pkg::state_e st_q, st_d;

  logic [7:0]  addr_q;
  logic [CW-1:0] cnt_q;
  logic [15:0] crc_q, crc_d;
  logic        rx_acc, tx_acc;

  // frame ram ports
  logic          fwe;
  logic [FAW-1:0] fwa, fra;
  logic [7:0]    frd;
  // word ram ports
  logic          wwe;
  logic [MAW-1:0] wwa, wra;
  logic [15:0]   wwd, wrd;

  // judged frame header
  logic [7:0]  fn_q;
  logic [15:0] wad_q, qty_q;
  logic [2:0]  hix_q;
  logic [7:0]  hb_q [6];
  logic [MAW:0] clr_q;
  logic [15:0] j_q;
  logic [7:0]  hi_q;
  logic [6:0]  tn_q, tk_q;
  logic [15:0] tcrc_q;
  logic [7:0]  tbyte_q;
  logic        tval_q, tlast_q;
  logic [7:0]  rdw_q;

  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i == mbrs_pkg::RegSlaveAddr) ? {24'h0, addr_q} : 32'h0;
  assign rx_acc = rx_valid_i && !rx_stall_o;
  assign tx_acc = tval_q && !tx_stall_i;
  assign rx_stall_o = (st_q != mbrs_pkg::ST_IDLE);
  assign tx_valid_o = tval_q;
  assign tx_byte_o = tbyte_q;
  assign tx_last_o = tlast_q;

  mbrs_ram #(.Width(8), .Depth(FRAME_BYTES)) u_frame (
    .clk_i, .we_i(fwe), .waddr_i(fwa), .wdata_i(rx_byte_i), .raddr_i(fra), .rdata_o(frd)
  );
  mbrs_ram #(.Width(16), .Depth(MEM_WORDS)) u_words (
    .clk_i, .we_i(wwe), .waddr_i(wwa), .wdata_i(wwd), .raddr_i(wra), .rdata_o(wrd)
  );

  // response byte k: header, data or tail of echo
  logic [6:0] tk_m3;
  logic       odd_dat;
  assign tk_m3 = tk_q - 7'd3;
  assign odd_dat = tk_m3[0];

  // judge conditions
  logic ok_base, len8, lenn;
  assign ok_base = (cnt_q >= CW'(8)) && (cnt_q <= FrameFull) && (crc_q == 16'h0)
                   && (hb_q[0] == addr_q);
  assign len8 = (cnt_q == CW'(8));
  assign lenn = ({1'b0, qty_q, 1'b0} + 18'd9) == 18'(cnt_q);

  // frame ram addressing
  always_comb begin
    fwe = rx_acc && (cnt_q < FrameFull);
    fwa = cnt_q[FAW-1:0];
    fra = FAW'(hix_q);
    if (st_q == mbrs_pkg::ST_WRFETCH || st_q == mbrs_pkg::ST_WRLO) begin
      fra = FAW'(18'd7 + {1'b0, j_q, 1'b0} + ((st_q == mbrs_pkg::ST_WRLO) ? 18'd1 : 18'd0));
    end
  end

  // word ram addressing
  always_comb begin
    wra = MAW'(wad_q + j_q);
    wwa = (st_q == mbrs_pkg::ST_CLEAR) ? clr_q[MAW-1:0] : MAW'(wad_q + j_q);
    wwd = 16'h0;
    wwe = 1'b0;
    if (st_q == mbrs_pkg::ST_CLEAR) begin
      wwe = 1'b1;
    end else if (st_q == mbrs_pkg::ST_WRMEM) begin
      wwe = 1'b1;
      wwd = {hi_q, frd};
    end else if (st_q == mbrs_pkg::ST_JUDGE && fn_q == mbrs_pkg::FnWrite1 && ok_base && len8) begin
      wwe = 1'b1;
      wwa = MAW'(wad_q);
      wwd = qty_q;
    end
  end

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      mbrs_pkg::ST_CLEAR: if (clr_q == (MAW+1)'(MEM_WORDS - 1)) st_d = mbrs_pkg::ST_IDLE;
      mbrs_pkg::ST_IDLE:  if (rx_acc && frame_end_i) st_d = mbrs_pkg::ST_HDR;
      mbrs_pkg::ST_HDR:   if (hix_q == 3'd6) st_d = mbrs_pkg::ST_JUDGE;
      mbrs_pkg::ST_JUDGE: begin
        st_d = mbrs_pkg::ST_IDLE;
        if (ok_base) begin
          case (fn_q)
            mbrs_pkg::FnRead:
              if (len8 && qty_q <= 16'(MAX_READ_WORDS)) st_d = mbrs_pkg::ST_EMIT;
            mbrs_pkg::FnWrite1: if (len8) st_d = mbrs_pkg::ST_EMIT;
            mbrs_pkg::FnWriteN:
              if (lenn) st_d = (qty_q == 16'h0) ? mbrs_pkg::ST_EMIT : mbrs_pkg::ST_WRFETCH;
            default: st_d = mbrs_pkg::ST_IDLE;
          endcase
        end
      end
      mbrs_pkg::ST_WRFETCH: st_d = mbrs_pkg::ST_WRLO;
      mbrs_pkg::ST_WRLO:    st_d = mbrs_pkg::ST_WRMEM;
      mbrs_pkg::ST_WRMEM:
        st_d = (j_q + 16'd1 == qty_q) ? mbrs_pkg::ST_EMIT : mbrs_pkg::ST_WRFETCH;
      mbrs_pkg::ST_EMIT:
        if (!tval_q || tx_acc) st_d = (tk_q == tn_q) ? mbrs_pkg::ST_CRCLO : mbrs_pkg::ST_RDREQ;
      mbrs_pkg::ST_RDREQ:  st_d = mbrs_pkg::ST_RDWAIT;
      mbrs_pkg::ST_RDWAIT: st_d = mbrs_pkg::ST_EMIT;
      mbrs_pkg::ST_CRCLO:  if (!tval_q || tx_acc) st_d = mbrs_pkg::ST_CRCHI;
      mbrs_pkg::ST_CRCHI:  if (!tval_q || tx_acc) st_d = mbrs_pkg::ST_IDLE;
      default: st_d = mbrs_pkg::ST_IDLE;
    endcase
  end

  // next byte to send, valid in ST_RDWAIT (data ready next edge)
  logic [7:0] nxt_byte;
  always_comb begin
    nxt_byte = frd;
    if (fn_q == mbrs_pkg::FnRead) begin
      if (tk_q == 7'd0) nxt_byte = addr_q;
      else if (tk_q == 7'd1) nxt_byte = mbrs_pkg::FnRead;
      else if (tk_q == 7'd2) nxt_byte = {qty_q[6:0], 1'b0};
      else nxt_byte = odd_dat ? rdw_q : wrd[15:8];
    end else begin
      nxt_byte = hb_q[tk_q[2:0]];
    end
  end

  assign crc_d = mbrs_pkg::crc_byte(crc_q, rx_byte_i);

  // control and payload registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= mbrs_pkg::ST_CLEAR;
      addr_q <= mbrs_pkg::AddrReset;
      cnt_q  <= '0;
      crc_q  <= mbrs_pkg::CrcInit;
      clr_q  <= '0;
      tval_q <= 1'b0;
      tlast_q <= 1'b0;
      hix_q  <= '0;
      tk_q   <= '0;
      j_q    <= '0;
    end else begin
      st_q <= st_d;
      if (psel_i && penable_i && pwrite_i && paddr_i == mbrs_pkg::RegSlaveAddr) begin
        addr_q <= pwdata_i[7:0];
      end
      if (st_q == mbrs_pkg::ST_CLEAR) clr_q <= clr_q + (MAW+1)'(1);
      if (tx_acc) tval_q <= 1'b0;
      if (rx_acc) begin
        crc_q <= crc_d;
        if (cnt_q != FrameOvf) cnt_q <= cnt_q + CW'(1);
        hix_q <= '0;
      end
      // header gather: addresses 0..5, data in the next cycle
      if (st_q == mbrs_pkg::ST_HDR) begin
        hix_q <= hix_q + 3'd1;
        if (hix_q != 3'd0) hb_q[hix_q - 3'd1] <= frd;
      end
      if (st_q == mbrs_pkg::ST_JUDGE) begin
        cnt_q <= '0;
        crc_q <= mbrs_pkg::CrcInit;
        j_q <= '0;
        tk_q <= '0;
        tcrc_q <= mbrs_pkg::CrcInit;
        tn_q <= (hb_q[1] == mbrs_pkg::FnRead) ? 7'(7'd3 + {qty_q[5:0], 1'b0}) : 7'd6;
      end
      if (st_q == mbrs_pkg::ST_WRLO) hi_q <= frd;
      if (st_q == mbrs_pkg::ST_WRMEM) j_q <= j_q + 16'd1;
      if (st_q == mbrs_pkg::ST_RDWAIT) begin
        tbyte_q <= nxt_byte;
        tlast_q <= 1'b0;
        tval_q  <= 1'b1;
        tcrc_q  <= mbrs_pkg::crc_byte(tcrc_q, nxt_byte);
        tk_q    <= tk_q + 7'd1;
        if (fn_q == mbrs_pkg::FnRead && tk_q >= 7'd3) begin
          if (!odd_dat) rdw_q <= wrd[7:0];
          else j_q <= j_q + 16'd1;
        end
      end
      if (st_q == mbrs_pkg::ST_EMIT && (!tval_q || tx_acc) && tk_q == tn_q) begin
        tbyte_q <= tcrc_q[7:0];
        tlast_q <= 1'b0;
        tval_q  <= 1'b1;
      end
      if (st_q == mbrs_pkg::ST_CRCLO && (!tval_q || tx_acc)) begin
        tbyte_q <= tcrc_q[15:8];
        tlast_q <= 1'b1;
        tval_q  <= 1'b1;
      end
    end
  end

  // header words decoded from gathered bytes
  always_comb begin
    fn_q  = hb_q[1];
    wad_q = {hb_q[2], hb_q[3]};
    qty_q = {hb_q[4], hb_q[5]};
  end

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tval_q && tx_stall_i |=> tval_q && $stable(tbyte_q))
    else $error("stalled tx beat changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != mbrs_pkg::ST_IDLE |-> rx_stall_o)
    else $error("rx taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_acc && tlast_q |=> st_q == mbrs_pkg::ST_IDLE)
    else $error("last beat did not end the response");

endmodule
